### src/dpa_se_pkg.sv
// Package for the DPA subcarrier estimate unit.
// Holds sample widths, fixed-point scale, pilot positions, symbol codes and rounding.
// No dependencies.
package dpa_se_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int IDX_BITS    = 6;

  localparam int PROD_BITS  = 2 * SAMPLE_BITS;
  localparam int SUM_BITS   = PROD_BITS + 1;
  localparam int TERM_BITS  = SAMPLE_BITS + 2;
  localparam int SCALE_BITS = 16;
  localparam int SCALE_SHIFT = 15;
  localparam int SCALED_BITS = TERM_BITS + SCALE_BITS;
  localparam int ROUND_BITS  = SCALED_BITS - SCALE_SHIFT;

  localparam logic signed [SCALE_BITS-1:0] DPA_SCALE = 16'sd23170;

  localparam logic [IDX_BITS-1:0] PILOT_A   = 6'd6;
  localparam logic [IDX_BITS-1:0] PILOT_B   = 6'd20;
  localparam logic [IDX_BITS-1:0] PILOT_C   = 6'd31;
  localparam logic [IDX_BITS-1:0] PILOT_NEG = 6'd45;

  localparam logic signed [1:0] SYM_POS  = 2'sb01;
  localparam logic signed [1:0] SYM_NEG  = 2'sb11;
  localparam logic signed [1:0] SYM_ZERO = 2'sb00;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [TERM_BITS-1:0]   term_t;
  typedef logic signed [SCALED_BITS-1:0] scaled_t;

  // round half up, drop the scale fraction, saturate
  function automatic sample_t round_sat(input scaled_t p);
    scaled_t                      b;
    logic signed [ROUND_BITS-1:0] r;
    sample_t                      y;
    b = p + SCALED_BITS'(2 ** (SCALE_SHIFT - 1));
    r = b[SCALED_BITS-1:SCALE_SHIFT];
    if (r[ROUND_BITS-1:SAMPLE_BITS-1] == '0 || r[ROUND_BITS-1:SAMPLE_BITS-1] == '1) begin
      y = r[SAMPLE_BITS-1:0];
    end else begin
      y = r[ROUND_BITS-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
    return y;
  endfunction

  // saturating negate
  function automatic sample_t neg_sat(input sample_t x);
    logic signed [SAMPLE_BITS:0] n;
    sample_t                     y;
    n = -{x[SAMPLE_BITS-1], x};
    if (n[SAMPLE_BITS] != n[SAMPLE_BITS-1]) begin
      y = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else begin
      y = n[SAMPLE_BITS-1:0];
    end
    return y;
  endfunction

endpackage

### src/dpa_subcarrier_estimate_unit.sv
// An accepted word passes registers s1 to s4 and then the output register.
// Throughput: one word per cycle; a stalled output word holds the whole pipeline.
// The stage carrying the two scale multipliers bounds the clock.
// Reset (rst_ni low, asynchronous) clears all valid bits; payload is not reset.
// Uses dpa_se_pkg.
module dpa_subcarrier_estimate_unit
  import dpa_se_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [IDX_BITS-1:0]        subcarrier_index_i,
  input  logic signed [SAMPLE_BITS-1:0] rx_re_i,
  input  logic signed [SAMPLE_BITS-1:0] rx_im_i,
  input  logic signed [SAMPLE_BITS-1:0] chan_re_i,
  input  logic signed [SAMPLE_BITS-1:0] chan_im_i,
  input  logic signed [SAMPLE_BITS-1:0] prior_re_i,
  input  logic signed [SAMPLE_BITS-1:0] prior_im_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       is_pilot_o,
  output logic signed [1:0]          symbol_re_o,
  output logic signed [1:0]          symbol_im_o,
  output logic signed [SAMPLE_BITS-1:0] dpa_re_o,
  output logic signed [SAMPLE_BITS-1:0] dpa_im_o,
  output logic signed [SAMPLE_BITS-1:0] avg_re_o,
  output logic signed [SAMPLE_BITS-1:0] avg_im_o
);

  logic adv;

  // stage 1: cross products, pilot decode
  logic                         s1_valid_q;
  logic                         s1_pilot_q, s1_pilot_d;
  logic                         s1_negp_q, s1_negp_d;
  sample_t                      s1_rr_q, s1_ri_q, s1_pr_q, s1_pi_q;
  sample_t                      s1_pv_re_q, s1_pv_re_d, s1_pv_im_q, s1_pv_im_d;
  logic signed [PROD_BITS-1:0]  s1_rrcr_q, s1_rici_q, s1_ricr_q, s1_rrci_q;

  // stage 2: decision and conjugate product
  logic                         s2_valid_q;
  logic                         s2_pilot_q, s2_negp_q;
  logic                         s2_sr_neg_q, s2_sr_neg_d, s2_si_neg_q, s2_si_neg_d;
  term_t                        s2_t_re_q, s2_t_re_d, s2_t_im_q, s2_t_im_d;
  sample_t                      s2_pr_q, s2_pi_q, s2_pv_re_q, s2_pv_im_q;
  logic signed [SUM_BITS-1:0]   sum_re, sum_im;

  // stage 3: scale
  logic                         s3_valid_q;
  logic                         s3_pilot_q, s3_negp_q, s3_sr_neg_q, s3_si_neg_q;
  scaled_t                      s3_p_re_q, s3_p_im_q;
  sample_t                      s3_pr_q, s3_pi_q, s3_pv_re_q, s3_pv_im_q;

  // stage 4: round, saturate, select
  logic                         s4_valid_q;
  logic                         s4_pilot_q;
  logic signed [1:0]            s4_sym_re_q, s4_sym_re_d, s4_sym_im_q, s4_sym_im_d;
  sample_t                      s4_dpa_re_q, s4_dpa_re_d, s4_dpa_im_q, s4_dpa_im_d;
  sample_t                      s4_pr_q, s4_pi_q;

  // stage 5: output word
  logic                         out_valid_q;
  logic                         out_pilot_q;
  logic signed [1:0]            out_sym_re_q, out_sym_im_q;
  sample_t                      out_dpa_re_q, out_dpa_im_q;
  sample_t                      out_avg_re_q, out_avg_re_d, out_avg_im_q, out_avg_im_d;
  logic signed [SAMPLE_BITS:0]  avg_sum_re, avg_sum_im;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  always_comb begin
    s1_negp_d  = (subcarrier_index_i == PILOT_NEG);
    s1_pilot_d = s1_negp_d || (subcarrier_index_i == PILOT_A) ||
                 (subcarrier_index_i == PILOT_B) || (subcarrier_index_i == PILOT_C);
    s1_pv_re_d = s1_negp_d ? neg_sat(rx_re_i) : rx_re_i;
    s1_pv_im_d = s1_negp_d ? neg_sat(rx_im_i) : rx_im_i;
  end

  always_comb begin
    sum_re = SUM_BITS'(s1_rrcr_q) + SUM_BITS'(s1_rici_q);
    sum_im = SUM_BITS'(s1_ricr_q) - SUM_BITS'(s1_rrci_q);
    s2_sr_neg_d = sum_re[SUM_BITS-1];
    s2_si_neg_d = sum_im[SUM_BITS-1];
    s2_t_re_d = (s2_sr_neg_d ? -TERM_BITS'(s1_rr_q) : TERM_BITS'(s1_rr_q)) +
                (s2_si_neg_d ? -TERM_BITS'(s1_ri_q) : TERM_BITS'(s1_ri_q));
    s2_t_im_d = (s2_sr_neg_d ? -TERM_BITS'(s1_ri_q) : TERM_BITS'(s1_ri_q)) +
                (s2_si_neg_d ? TERM_BITS'(s1_rr_q) : -TERM_BITS'(s1_rr_q));
  end

  always_comb begin
    if (s3_pilot_q) begin
      s4_sym_re_d = s3_negp_q ? SYM_NEG : SYM_POS;
      s4_sym_im_d = SYM_ZERO;
      s4_dpa_re_d = s3_pv_re_q;
      s4_dpa_im_d = s3_pv_im_q;
    end else begin
      s4_sym_re_d = s3_sr_neg_q ? SYM_NEG : SYM_POS;
      s4_sym_im_d = s3_si_neg_q ? SYM_NEG : SYM_POS;
      s4_dpa_re_d = round_sat(s3_p_re_q);
      s4_dpa_im_d = round_sat(s3_p_im_q);
    end
  end

  always_comb begin
    avg_sum_re   = (SAMPLE_BITS + 1)'(s4_dpa_re_q) + (SAMPLE_BITS + 1)'(s4_pr_q);
    avg_sum_im   = (SAMPLE_BITS + 1)'(s4_dpa_im_q) + (SAMPLE_BITS + 1)'(s4_pi_q);
    out_avg_re_d = avg_sum_re[SAMPLE_BITS:1];
    out_avg_im_d = avg_sum_im[SAMPLE_BITS:1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      out_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_pilot_q  <= s1_pilot_d;
      s1_negp_q   <= s1_negp_d;
      s1_rr_q     <= rx_re_i;
      s1_ri_q     <= rx_im_i;
      s1_pr_q     <= prior_re_i;
      s1_pi_q     <= prior_im_i;
      s1_pv_re_q  <= s1_pv_re_d;
      s1_pv_im_q  <= s1_pv_im_d;
      s1_rrcr_q   <= rx_re_i * chan_re_i;
      s1_rici_q   <= rx_im_i * chan_im_i;
      s1_ricr_q   <= rx_im_i * chan_re_i;
      s1_rrci_q   <= rx_re_i * chan_im_i;

      s2_pilot_q  <= s1_pilot_q;
      s2_negp_q   <= s1_negp_q;
      s2_sr_neg_q <= s2_sr_neg_d;
      s2_si_neg_q <= s2_si_neg_d;
      s2_t_re_q   <= s2_t_re_d;
      s2_t_im_q   <= s2_t_im_d;
      s2_pr_q     <= s1_pr_q;
      s2_pi_q     <= s1_pi_q;
      s2_pv_re_q  <= s1_pv_re_q;
      s2_pv_im_q  <= s1_pv_im_q;

      s3_pilot_q  <= s2_pilot_q;
      s3_negp_q   <= s2_negp_q;
      s3_sr_neg_q <= s2_sr_neg_q;
      s3_si_neg_q <= s2_si_neg_q;
      s3_p_re_q   <= s2_t_re_q * DPA_SCALE;
      s3_p_im_q   <= s2_t_im_q * DPA_SCALE;
      s3_pr_q     <= s2_pr_q;
      s3_pi_q     <= s2_pi_q;
      s3_pv_re_q  <= s2_pv_re_q;
      s3_pv_im_q  <= s2_pv_im_q;

      s4_pilot_q  <= s3_pilot_q;
      s4_sym_re_q <= s4_sym_re_d;
      s4_sym_im_q <= s4_sym_im_d;
      s4_dpa_re_q <= s4_dpa_re_d;
      s4_dpa_im_q <= s4_dpa_im_d;
      s4_pr_q     <= s3_pr_q;
      s4_pi_q     <= s3_pi_q;

      out_pilot_q  <= s4_pilot_q;
      out_sym_re_q <= s4_sym_re_q;
      out_sym_im_q <= s4_sym_im_q;
      out_dpa_re_q <= s4_dpa_re_q;
      out_dpa_im_q <= s4_dpa_im_q;
      out_avg_re_q <= out_avg_re_d;
      out_avg_im_q <= out_avg_im_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign is_pilot_o  = out_pilot_q;
  assign symbol_re_o = out_sym_re_q;
  assign symbol_im_o = out_sym_im_q;
  assign dpa_re_o    = out_dpa_re_q;
  assign dpa_im_o    = out_dpa_im_q;
  assign avg_re_o    = out_avg_re_q;
  assign avg_im_o    = out_avg_im_q;

  a_pilot_sym: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_pilot_o |-> symbol_im_o == SYM_ZERO && symbol_re_o != SYM_ZERO)
    else $error("pilot word with bad symbol");

  a_data_sym: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_pilot_o |-> symbol_im_o != SYM_ZERO && symbol_re_o != SYM_ZERO)
    else $error("data word with zero symbol");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> s1_valid_q)
    else $error("accepted word lost at entry");

  a_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_valid_q && adv |=> out_valid_q)
    else $error("word lost at output stage");

endmodule

### dv/dpa_subcarrier_estimate_unit_test.sv
// Self-checking bench for dpa_subcarrier_estimate_unit: a directed table, then random
// subcarrier words, each checked against table values or a fixed-point DPA estimate predictor.
// Depends on dpa_se_pkg and the unit itself.
module dpa_subcarrier_estimate_unit_test;
  import dpa_se_pkg::*;

  typedef struct packed {
    logic [IDX_BITS-1:0] idx;
    sample_t             rx_re;
    sample_t             rx_im;
    sample_t             chan_re;
    sample_t             chan_im;
    sample_t             prior_re;
    sample_t             prior_im;
  } subcarrier_word_t;

  typedef struct packed {
    logic              pilot;
    logic signed [1:0] sym_re;
    logic signed [1:0] sym_im;
    sample_t           dpa_re;
    sample_t           dpa_im;
    sample_t           avg_re;
    sample_t           avg_im;
  } estimate_t;

  typedef struct {
    int idx, rx_re, rx_im, chan_re, chan_im, prior_re, prior_im;
    bit known;
    int pilot, sym_re, sym_im, dpa_re, dpa_im, avg_re, avg_im;
  } directed_row_t;

  localparam longint DPA_GAIN   = 23170;
  localparam int     GAIN_SHIFT = 15;
  localparam int     NUM_DIRECTED = 22;
  localparam int     NUM_RANDOM   = 550;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [IDX_BITS-1:0] subcarrier_index_i;
  sample_t             rx_re_i;
  sample_t             rx_im_i;
  sample_t             chan_re_i;
  sample_t             chan_im_i;
  sample_t             prior_re_i;
  sample_t             prior_im_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                is_pilot_o;
  logic signed [1:0]   symbol_re_o;
  logic signed [1:0]   symbol_im_o;
  sample_t             dpa_re_o;
  sample_t             dpa_im_o;
  sample_t             avg_re_o;
  sample_t             avg_im_o;

  estimate_t pending_estimates[$];
  int        words_sent;
  int        words_checked;
  int        pilot_words;
  int        saturated_words;
  int        mismatches;

  directed_row_t directed_words[NUM_DIRECTED] = '{
    '{6, 32767, -32768, 0, 0, 32767, -32768,
      1, 1, SYM_POS, SYM_ZERO, 32767, -32768, 32767, -32768},
    '{20, 100, -100, -5, 7, -1, 1,
      1, 1, SYM_POS, SYM_ZERO, 100, -100, 49, -50},
    '{31, 0, 0, 32767, 32767, -1, -1,
      1, 1, SYM_POS, SYM_ZERO, 0, 0, -1, -1},
    '{45, -32768, 32767, 0, 0, 0, 0,
      1, 1, SYM_NEG, SYM_ZERO, 32767, -32767, 16383, -16384},
    '{45, 5, -3, 100, 100, 1, 1,
      1, 1, SYM_NEG, SYM_ZERO, -5, 3, -2, 2},
    '{6, -32768, -1, -32768, 32767, -32768, -32768,
      1, 1, SYM_POS, SYM_ZERO, -32768, -1, -32768, -16385},
    '{0, 0, 0, 0, 0, 0, 0,
      1, 0, SYM_POS, SYM_POS, 0, 0, 0, 0},
    '{2, 32767, 32767, 1, -1, 32767, 32767,
      1, 0, SYM_POS, SYM_POS, 32767, 0, 32767, 16383},
    '{51, -32768, -32768, 1, -1, -32768, -32768,
      1, 0, SYM_POS, SYM_NEG, 0, -32768, -16384, -32768},
    '{1, 4096, -4096, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{10, 3000, 2000, 4096, 0, 100, -100, 0, 0, 0, 0, 0, 0, 0, 0},
    '{11, -3000, 2000, 4096, 0, -7, 7, 0, 0, 0, 0, 0, 0, 0, 0},
    '{12, -3000, -2000, 4096, 0, 32767, -32768, 0, 0, 0, 0, 0, 0, 0, 0},
    '{13, 3000, -2000, 4096, 0, -32768, 32767, 0, 0, 0, 0, 0, 0, 0, 0},
    '{44, 1000, 0, 0, 1000, 3, -3, 0, 0, 0, 0, 0, 0, 0, 0},
    '{46, 0, 1000, 0, 1000, -3, 3, 0, 0, 0, 0, 0, 0, 0, 0},
    '{52, 1234, -4321, -2048, 512, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{63, -32768, 32767, 32767, -32768, 32767, 32767, 0, 0, 0, 0, 0, 0, 0, 0},
    '{5, 1, -1, -1, 1, -1, 1, 0, 0, 0, 0, 0, 0, 0, 0},
    '{7, -1, 1, 1, 1, 1, -1, 0, 0, 0, 0, 0, 0, 0, 0},
    '{30, -32768, 32767, -32768, -32768, -32768, 32767, 0, 0, 0, 0, 0, 0, 0, 0},
    '{21, 32767, -32768, -32768, 32767, 32767, 32767, 0, 0, 0, 0, 0, 0, 0, 0}
  };

  dpa_subcarrier_estimate_unit dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic longint clip_sample(input longint x);
    longint hi;
    hi = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    if (x > hi) begin
      return hi;
    end else if (x < -hi - 1) begin
      return -hi - 1;
    end
    return x;
  endfunction

  function automatic estimate_t predict_estimate(input subcarrier_word_t w);
    longint    rr, ri, cr, ci, tr, ti, dr, di;
    int        sr, si;
    estimate_t e;
    rr = w.rx_re;
    ri = w.rx_im;
    cr = w.chan_re;
    ci = w.chan_im;
    e.pilot = 1'b1;
    if (w.idx == PILOT_A || w.idx == PILOT_B || w.idx == PILOT_C) begin
      sr = 1;
      si = 0;
      dr = rr;
      di = ri;
    end else if (w.idx == PILOT_NEG) begin
      sr = -1;
      si = 0;
      dr = clip_sample(-rr);
      di = clip_sample(-ri);
    end else begin
      e.pilot = 1'b0;
      sr = (rr * cr + ri * ci >= 0) ? 1 : -1;
      si = (ri * cr - rr * ci >= 0) ? 1 : -1;
      tr = rr * sr + ri * si;
      ti = ri * sr - rr * si;
      dr = clip_sample((tr * DPA_GAIN + (longint'(1) << (GAIN_SHIFT - 1))) >>> GAIN_SHIFT);
      di = clip_sample((ti * DPA_GAIN + (longint'(1) << (GAIN_SHIFT - 1))) >>> GAIN_SHIFT);
    end
    e.sym_re = (sr > 0) ? SYM_POS : SYM_NEG;
    e.sym_im = (si == 0) ? SYM_ZERO : ((si > 0) ? SYM_POS : SYM_NEG);
    e.dpa_re = sample_t'(dr);
    e.dpa_im = sample_t'(di);
    e.avg_re = sample_t'((dr + longint'(w.prior_re)) >>> 1);
    e.avg_im = sample_t'((di + longint'(w.prior_im)) >>> 1);
    return e;
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(4))
          0: s = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
          1: s = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
          2: s = '0;
          3: s = '1;
          default: s = sample_t'(1);
        endcase
      end
      1: s = sample_t'($urandom_range(511)) - sample_t'(256);
      default: s = sample_t'($urandom);
    endcase
    return s;
  endfunction

  function automatic subcarrier_word_t random_word();
    subcarrier_word_t w;
    case ($urandom_range(9))
      0, 1: begin
        case ($urandom_range(3))
          0: w.idx = PILOT_A;
          1: w.idx = PILOT_B;
          2: w.idx = PILOT_C;
          default: w.idx = PILOT_NEG;
        endcase
      end
      2: w.idx = IDX_BITS'($urandom_range(52, 63));
      default: w.idx = IDX_BITS'($urandom_range(51));
    endcase
    w.rx_re    = random_sample();
    w.rx_im    = random_sample();
    w.chan_re  = random_sample();
    w.chan_im  = random_sample();
    w.prior_re = random_sample();
    w.prior_im = random_sample();
    if ($urandom_range(9) == 0) begin
      w.chan_re = '0;
    end
    if ($urandom_range(9) == 0) begin
      w.chan_im = '0;
    end
    return w;
  endfunction

  function automatic bit quiet_stretch();
    return words_sent >= 250 && words_sent < 350;
  endfunction

  task automatic send_word(input subcarrier_word_t w, input estimate_t e);
    if (!quiet_stretch()) begin
      while ($urandom_range(99) < 13) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i         <= 1'b1;
    subcarrier_index_i <= w.idx;
    rx_re_i            <= w.rx_re;
    rx_im_i            <= w.rx_im;
    chan_re_i          <= w.chan_re;
    chan_im_i          <= w.chan_im;
    prior_re_i         <= w.prior_re;
    prior_im_i         <= w.prior_im;
    do @(posedge clk_i); while (in_stall_o);
    pending_estimates.push_back(e);
    words_sent++;
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  initial begin
    estimate_t want;
    estimate_t got;
    int        holdoff_left;
    bit        holdoff_done;
    holdoff_left = 0;
    holdoff_done = 1'b0;
    out_stall_i  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got = '{is_pilot_o, symbol_re_o, symbol_im_o, dpa_re_o, dpa_im_o, avg_re_o, avg_im_o};
        if (pending_estimates.size() == 0) begin
          $error("output word with no pending estimate");
          mismatches++;
        end else begin
          want = pending_estimates.pop_front();
          check_field("is_pilot", want.pilot, got.pilot);
          check_field("symbol_re", want.sym_re, got.sym_re);
          check_field("symbol_im", want.sym_im, got.sym_im);
          check_field("dpa_re", want.dpa_re, got.dpa_re);
          check_field("dpa_im", want.dpa_im, got.dpa_im);
          check_field("avg_re", want.avg_re, got.avg_re);
          check_field("avg_im", want.avg_im, got.avg_im);
        end
        words_checked++;
        pilot_words += got.pilot;
        if (got.dpa_re == {1'b0, {(SAMPLE_BITS-1){1'b1}}} ||
            got.dpa_re == {1'b1, {(SAMPLE_BITS-1){1'b0}}} ||
            got.dpa_im == {1'b0, {(SAMPLE_BITS-1){1'b1}}} ||
            got.dpa_im == {1'b1, {(SAMPLE_BITS-1){1'b0}}}) begin
          saturated_words++;
        end
      end
      if (holdoff_left > 0) begin
        out_stall_i <= 1'b1;
        holdoff_left--;
      end else if (!holdoff_done && words_sent >= 150) begin
        out_stall_i  <= 1'b1;
        holdoff_left = 80;
        holdoff_done = 1'b1;
      end else if (quiet_stretch()) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < 13);
      end
    end
  end

  initial begin
    subcarrier_word_t w;
    estimate_t        e;
    directed_row_t    r;
    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    subcarrier_index_i = '0;
    rx_re_i            = '0;
    rx_im_i            = '0;
    chan_re_i          = '0;
    chan_im_i          = '0;
    prior_re_i         = '0;
    prior_im_i         = '0;
    words_sent         = 0;
    words_checked      = 0;
    pilot_words        = 0;
    saturated_words    = 0;
    mismatches         = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      r = directed_words[i];
      w = '{IDX_BITS'(r.idx), sample_t'(r.rx_re), sample_t'(r.rx_im), sample_t'(r.chan_re),
            sample_t'(r.chan_im), sample_t'(r.prior_re), sample_t'(r.prior_im)};
      if (r.known) begin
        e = '{r.pilot[0], 2'(r.sym_re), 2'(r.sym_im), sample_t'(r.dpa_re),
              sample_t'(r.dpa_im), sample_t'(r.avg_re), sample_t'(r.avg_im)};
      end else begin
        e = predict_estimate(w);
      end
      send_word(w, e);
    end

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == 400) begin
        in_valid_i <= 1'b0;
        while (pending_estimates.size() != 0) @(posedge clk_i);
      end
      w = random_word();
      send_word(w, predict_estimate(w));
    end
    in_valid_i <= 1'b0;

    while (pending_estimates.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Checked %0d words: %0d pilots, %0d with a saturated estimate.",
             words_checked, pilot_words, saturated_words);
    $display("Runs included a long output hold-off and a full drain mid-stream.");
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### sim.f
src/dpa_se_pkg.sv
src/dpa_subcarrier_estimate_unit.sv
dv/dpa_subcarrier_estimate_unit_test.sv
